// ----- hw/rtl/nps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest polyline search package
// Shared types, codes and constants of the nearest polyline search unit.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int MAX_POINTS_DEF  = 1024;
    localparam int COORD_BITS_DEF  = 24;
    localparam int TAG_BITS        = 16;
    localparam int RANK_BITS       = 10;
    localparam int LIM_BITS        = 16;
    localparam int DIST_BITS       = 32;
    localparam int QUO_BITS        = 16;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 1;
    localparam logic [RANK_BITS-1:0] RANK_MAX = 10'd1023;
    localparam logic [LIM_BITS-1:0] LATERAL_LIMIT_RST = 16'd512;
    localparam logic [LIM_BITS-1:0] VERTEX_RADIUS_RST = 16'd768;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LATERAL_LIMIT = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VERTEX_RADIUS = 1'b1;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]           operation;
        logic [15:0]          boundary_tag;
        logic                 starts_boundary;
        logic signed [23:0]   coord_x;
        logic signed [23:0]   coord_y;
    } t_in;

    typedef struct packed {
        logic [1:0]           status;
        logic [15:0]          found_tag;
        logic [15:0]          lateral_distance;
        logic                 vertex_found;
        logic [9:0]           vertex_position;
        logic [31:0]          vertex_dist_sq;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_SEG_RD, S_SEG_LD, S_SEG_MUL, S_SEG_SUM, S_SEG_TEST,
        S_SQRT, S_SCALE, S_CHECK, S_DIV, S_SEG_UPD,
        S_VTX_RD, S_VTX_LD, S_VTX_MUL, S_VTX_SUM, S_VTX_UPD,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic q_init;
        logic rd;
        logic idx_inc;
        logic idx_clear;
        logic seg_load;
        logic seg_mul;
        logic seg_sum;
        logic sqrt_init;
        logic sqrt_step;
        logic scale;
        logic div_init;
        logic div_step;
        logic seg_update;
        logic vtx_load;
        logic vtx_mul;
        logic vtx_sum;
        logic vtx_update;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic idx_end;
        logic seg_here;
        logic seg_pass;
        logic iter_last;
        logic in_limit;
        logic seg_ok;
        logic tag_match;
        logic out_busy;
    } t_stat;

endpackage

// ----- hw/rtl/nearest_polyline_search_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest polyline search unit
// Point store with nearest segment and nearest vertex search.
// ----------------------------------------------------------------------------
// Input beats carry an operation: clear, append a point, or query. Each
// input beat produces exactly one output beat on the valid/ready result
// channel. The user must write registers through the plain write port
// only while idle; the block itself does not enforce this. A query walks
// the store through the single read port of the point memory, once for
// segments and, if one is found, once more for vertices. The segment walk
// reads each point; a segment is multiplied, summed and tested, one whose
// projection falls on it takes the root (one bit a cycle) and the limit
// check, and one within the lateral limit a 16-step divider and the update.
// The vertex walk reads each point and measures each one of the found tag.
// A new input beat is taken while a finished result still waits in the
// output register; if the receiver stalls, the next result waits in the
// response state until the held beat is taken. Reset empties the store
// and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module nearest_polyline_search_unit #(
    parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  nps_pkg::t_in                        i_in,
    output logic                                o_valid,
    input  logic                                i_ready,
    output nps_pkg::t_out                       o_out,
    input  logic                                i_cfg_we,
    input  logic [nps_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [nps_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    nps_pkg::t_cmd  w_cmd;
    nps_pkg::t_stat w_stat;

    nps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    nps_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_out       (o_out)
    );

endmodule

// ----- hw/rtl/nps_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest polyline search controller
// Sequences store updates, the segment walk and the vertex walk.
// ----------------------------------------------------------------------------
module nps_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  nps_pkg::t_stat i_stat,
    output nps_pkg::t_cmd  o_cmd
);

    nps_pkg::t_state r_state;
    nps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            nps_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = nps_pkg::S_DISPATCH;
                end
            end
            nps_pkg::S_DISPATCH: begin
                if (i_stat.op == nps_pkg::OP_QUERY) begin
                    o_cmd.q_init = 1'b1;
                    n_state      = nps_pkg::S_SEG_RD;
                end else begin
                    n_state = nps_pkg::S_RESP;
                end
            end
            nps_pkg::S_SEG_RD: begin
                if (i_stat.idx_end) begin
                    if (i_stat.seg_ok) begin
                        o_cmd.idx_clear = 1'b1;
                        n_state         = nps_pkg::S_VTX_RD;
                    end else begin
                        n_state = nps_pkg::S_RESP;
                    end
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = nps_pkg::S_SEG_LD;
                end
            end
            nps_pkg::S_SEG_LD: begin
                o_cmd.seg_load = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state = i_stat.seg_here ? nps_pkg::S_SEG_MUL : nps_pkg::S_SEG_RD;
            end
            nps_pkg::S_SEG_MUL: begin
                o_cmd.seg_mul = 1'b1;
                n_state       = nps_pkg::S_SEG_SUM;
            end
            nps_pkg::S_SEG_SUM: begin
                o_cmd.seg_sum = 1'b1;
                n_state       = nps_pkg::S_SEG_TEST;
            end
            nps_pkg::S_SEG_TEST: begin
                if (i_stat.seg_pass) begin
                    o_cmd.sqrt_init = 1'b1;
                    n_state         = nps_pkg::S_SQRT;
                end else begin
                    n_state = nps_pkg::S_SEG_RD;
                end
            end
            nps_pkg::S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_stat.iter_last) begin
                    n_state = nps_pkg::S_SCALE;
                end
            end
            nps_pkg::S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = nps_pkg::S_CHECK;
            end
            nps_pkg::S_CHECK: begin
                if (i_stat.in_limit) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = nps_pkg::S_DIV;
                end else begin
                    n_state = nps_pkg::S_SEG_RD;
                end
            end
            nps_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.iter_last) begin
                    n_state = nps_pkg::S_SEG_UPD;
                end
            end
            nps_pkg::S_SEG_UPD: begin
                o_cmd.seg_update = 1'b1;
                n_state          = nps_pkg::S_SEG_RD;
            end
            nps_pkg::S_VTX_RD: begin
                if (i_stat.idx_end) begin
                    n_state = nps_pkg::S_RESP;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = nps_pkg::S_VTX_LD;
                end
            end
            nps_pkg::S_VTX_LD: begin
                o_cmd.idx_inc = 1'b1;
                if (i_stat.tag_match) begin
                    o_cmd.vtx_load = 1'b1;
                    n_state        = nps_pkg::S_VTX_MUL;
                end else begin
                    n_state = nps_pkg::S_VTX_RD;
                end
            end
            nps_pkg::S_VTX_MUL: begin
                o_cmd.vtx_mul = 1'b1;
                n_state       = nps_pkg::S_VTX_SUM;
            end
            nps_pkg::S_VTX_SUM: begin
                o_cmd.vtx_sum = 1'b1;
                n_state       = nps_pkg::S_VTX_UPD;
            end
            nps_pkg::S_VTX_UPD: begin
                o_cmd.vtx_update = 1'b1;
                n_state          = nps_pkg::S_VTX_RD;
            end
            nps_pkg::S_RESP: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = nps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nps_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/nps_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest polyline search datapath
// Point store, segment and vertex arithmetic, iterative root and divider.
// ----------------------------------------------------------------------------
module nps_dp #(
    parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  nps_pkg::t_in                        i_in,
    input  logic                                i_cfg_we,
    input  logic [nps_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [nps_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  nps_pkg::t_cmd                       i_cmd,
    output nps_pkg::t_stat                      o_stat,
    input  logic                                i_ready,
    output logic                                o_valid,
    output nps_pkg::t_out                       o_out
);

    localparam int CW   = COORD_BITS;
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * DW;
    localparam int SW   = PW + 1;
    localparam int LW   = PW;
    localparam int RW   = DW;
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam int QB   = nps_pkg::QUO_BITS;
    localparam int REMW = RW + QB;
    localparam int BW   = RW + nps_pkg::LIM_BITS + 1;
    localparam int CMPW = (SW > BW) ? SW : BW;
    localparam int EW   = (LW > nps_pkg::DIST_BITS) ? LW : nps_pkg::DIST_BITS;
    localparam int ITW  = $clog2((RW > QB) ? RW : QB);

    logic signed [CW-1:0]              m_x    [MAX_POINTS];
    logic signed [CW-1:0]              m_y    [MAX_POINTS];
    logic [nps_pkg::TAG_BITS-1:0]      m_tag  [MAX_POINTS];
    logic [nps_pkg::RANK_BITS-1:0]     m_rank [MAX_POINTS];

    nps_pkg::t_op                      r_op;
    logic                              r_drop;
    logic signed [CW-1:0]              r_qx, r_qy;
    logic [CNTW-1:0]                   r_count;
    logic [nps_pkg::RANK_BITS-1:0]     r_last_rank;
    logic [nps_pkg::LIM_BITS-1:0]      r_lat_lim, r_vtx_rad;
    logic [nps_pkg::DIST_BITS-1:0]     r_rad2;
    logic signed [CW-1:0]              r_rd_x, r_rd_y;
    logic [nps_pkg::TAG_BITS-1:0]      r_rd_tag;
    logic [nps_pkg::RANK_BITS-1:0]     r_rd_rank;
    logic [CNTW-1:0]                   r_idx;
    logic signed [CW-1:0]              r_px, r_py;
    logic [nps_pkg::TAG_BITS-1:0]      r_ptag, r_seg_tag;
    logic signed [DW-1:0]              r_sx, r_sy, r_dx, r_dy;
    logic signed [PW-1:0]              r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic [LW-1:0]                     r_len2;
    logic signed [SW-1:0]              r_ip;
    logic [SW-1:0]                     r_acr;
    logic [LW-1:0]                     r_sq_v, r_sq_res, r_sq_bit;
    logic [ITW-1:0]                    r_iter;
    logic [BW-1:0]                     r_bound;
    logic [REMW-1:0]                   r_rem, r_dvs;
    logic [QB-1:0]                     r_quo;
    logic                              r_seg_ok, r_v_ok;
    logic [nps_pkg::LIM_BITS-1:0]      r_best_lat;
    logic [nps_pkg::TAG_BITS-1:0]      r_best_tag;
    logic [LW-1:0]                     r_d2;
    logic [nps_pkg::DIST_BITS-1:0]     r_best_d2;
    logic [nps_pkg::RANK_BITS-1:0]     r_best_rank;
    nps_pkg::t_out                     r_out;
    logic                              r_out_valid;

    logic signed [CW-1:0]              w_cx, w_cy;
    logic [nps_pkg::RANK_BITS-1:0]     w_rank;
    logic                              w_full;
    logic signed [SW-1:0]              w_cr;
    logic [LW-1:0]                     w_trial;
    logic [RW-1:0]                     w_root;
    nps_pkg::t_out                     w_res;

    function automatic logic t_op_is_append(input logic [1:0] op);
        t_op_is_append = (nps_pkg::t_op'(op) == nps_pkg::OP_APPEND);
    endfunction

    assign w_cx   = CW'(i_in.coord_x);
    assign w_cy   = CW'(i_in.coord_y);
    assign w_full = (r_count == CNTW'(MAX_POINTS));
    assign w_rank = (i_in.starts_boundary || r_count == '0) ? '0 :
                    (r_last_rank >= nps_pkg::RANK_MAX) ? nps_pkg::RANK_MAX :
                    r_last_rank + 1'b1;
    assign w_cr    = SW'(r_p4) - SW'(r_p5);
    assign w_trial = r_sq_res + r_sq_bit;
    assign w_root  = r_sq_res[RW-1:0];

    assign o_stat.op        = r_op;
    assign o_stat.idx_end   = (r_idx >= r_count);
    assign o_stat.seg_here  = (r_idx != '0) && (r_rd_rank != '0);
    assign o_stat.seg_pass  = (r_len2 != '0) && !r_ip[SW-1]
                              && (r_ip <= $signed({1'b0, r_len2}));
    assign o_stat.iter_last = (r_iter == '0);
    assign o_stat.in_limit  = (CMPW'(r_acr) < CMPW'(r_bound));
    assign o_stat.seg_ok    = r_seg_ok;
    assign o_stat.tag_match = (r_rd_tag == r_best_tag);
    assign o_stat.out_busy  = r_out_valid && !i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && t_op_is_append(i_in.operation) && !w_full) begin
            m_x[r_count[AW-1:0]]    <= w_cx;
            m_y[r_count[AW-1:0]]    <= w_cy;
            m_tag[r_count[AW-1:0]]  <= i_in.boundary_tag;
            m_rank[r_count[AW-1:0]] <= w_rank;
        end
        if (i_cmd.rd) begin
            r_rd_x    <= m_x[r_idx[AW-1:0]];
            r_rd_y    <= m_y[r_idx[AW-1:0]];
            r_rd_tag  <= m_tag[r_idx[AW-1:0]];
            r_rd_rank <= m_rank[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_lat_lim <= nps_pkg::LATERAL_LIMIT_RST;
            r_vtx_rad <= nps_pkg::VERTEX_RADIUS_RST;
            r_op      <= nps_pkg::OP_NOP;
            r_drop    <= 1'b0;
            r_idx     <= '0;
            r_iter    <= '0;
            r_seg_ok  <= 1'b0;
            r_v_ok    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == nps_pkg::CFG_LATERAL_LIMIT) begin
                    r_lat_lim <= i_cfg_data;
                end else begin
                    r_vtx_rad <= i_cfg_data;
                end
            end
            if (i_cmd.load) begin
                r_op   <= nps_pkg::t_op'(i_in.operation);
                r_drop <= 1'b0;
                r_idx  <= '0;
                if (nps_pkg::t_op'(i_in.operation) == nps_pkg::OP_CLEAR) begin
                    r_count <= '0;
                end else if (t_op_is_append(i_in.operation)) begin
                    if (w_full) begin
                        r_drop <= 1'b1;
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                end
            end
            if (i_cmd.q_init) begin
                r_seg_ok <= 1'b0;
                r_v_ok   <= 1'b0;
            end
            if (i_cmd.idx_clear) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.sqrt_init) begin
                r_iter <= ITW'(RW - 1);
            end else if (i_cmd.div_init) begin
                r_iter <= ITW'(QB - 1);
            end else if ((i_cmd.sqrt_step || i_cmd.div_step) && r_iter != '0) begin
                r_iter <= r_iter - 1'b1;
            end
            if (i_cmd.seg_update && (!r_seg_ok || r_quo < r_best_lat)) begin
                r_seg_ok <= 1'b1;
            end
            if (i_cmd.vtx_update && EW'(r_d2) <= EW'(r_rad2)
                && (!r_v_ok || nps_pkg::DIST_BITS'(r_d2) < r_best_d2)) begin
                r_v_ok <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_qx <= w_cx;
            r_qy <= w_cy;
            if (t_op_is_append(i_in.operation) && !w_full) begin
                r_last_rank <= w_rank;
            end
        end
        if (i_cmd.q_init) begin
            r_rad2      <= nps_pkg::DIST_BITS'(r_vtx_rad * r_vtx_rad);
            r_best_lat  <= '0;
            r_best_tag  <= '0;
            r_best_d2   <= '0;
            r_best_rank <= '0;
        end
        if (i_cmd.seg_load) begin
            r_sx      <= DW'(r_rd_x) - DW'(r_px);
            r_sy      <= DW'(r_rd_y) - DW'(r_py);
            r_dx      <= DW'(r_qx) - DW'(r_px);
            r_dy      <= DW'(r_qy) - DW'(r_py);
            r_seg_tag <= r_ptag;
            r_px      <= r_rd_x;
            r_py      <= r_rd_y;
            r_ptag    <= r_rd_tag;
        end
        if (i_cmd.vtx_load) begin
            r_dx <= DW'(r_qx) - DW'(r_rd_x);
            r_dy <= DW'(r_qy) - DW'(r_rd_y);
        end
        if (i_cmd.seg_mul) begin
            r_p0 <= r_sx * r_sx;
            r_p1 <= r_sy * r_sy;
            r_p2 <= r_dx * r_sx;
            r_p3 <= r_dy * r_sy;
            r_p4 <= r_dy * r_sx;
            r_p5 <= r_dx * r_sy;
        end
        if (i_cmd.vtx_mul) begin
            r_p0 <= r_dx * r_dx;
            r_p1 <= r_dy * r_dy;
        end
        if (i_cmd.seg_sum) begin
            r_len2 <= LW'(r_p0) + LW'(r_p1);
            r_ip   <= SW'(r_p2) + SW'(r_p3);
            r_acr  <= w_cr[SW-1] ? SW'(-w_cr) : SW'(w_cr);
        end
        if (i_cmd.vtx_sum) begin
            r_d2 <= LW'(r_p0) + LW'(r_p1);
        end
        if (i_cmd.sqrt_init) begin
            r_sq_v   <= r_len2;
            r_sq_res <= '0;
            r_sq_bit <= LW'(1) << (LW - 2);
        end else if (i_cmd.sqrt_step) begin
            if (r_sq_v >= w_trial) begin
                r_sq_v   <= r_sq_v - w_trial;
                r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
            end else begin
                r_sq_res <= r_sq_res >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
        end
        if (i_cmd.scale) begin
            r_bound <= BW'({1'b0, r_lat_lim} + 17'd1) * BW'(w_root);
        end
        if (i_cmd.div_init) begin
            r_rem <= REMW'(r_acr);
            r_dvs <= REMW'(w_root) << (QB - 1);
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            if (r_rem >= r_dvs) begin
                r_rem <= r_rem - r_dvs;
                r_quo <= {r_quo[QB-2:0], 1'b1};
            end else begin
                r_quo <= {r_quo[QB-2:0], 1'b0};
            end
            r_dvs <= r_dvs >> 1;
        end
        if (i_cmd.seg_update && (!r_seg_ok || r_quo < r_best_lat)) begin
            r_best_lat <= r_quo;
            r_best_tag <= r_seg_tag;
        end
        if (i_cmd.vtx_update && EW'(r_d2) <= EW'(r_rad2)
            && (!r_v_ok || nps_pkg::DIST_BITS'(r_d2) < r_best_d2)) begin
            r_best_d2   <= nps_pkg::DIST_BITS'(r_d2);
            r_best_rank <= r_rd_rank;
        end
    end

    always_comb begin
        w_res = '0;
        unique case (r_op)
            nps_pkg::OP_QUERY: begin
                if (r_seg_ok) begin
                    w_res.status           = nps_pkg::ST_OK;
                    w_res.found_tag        = r_best_tag;
                    w_res.lateral_distance = r_best_lat;
                    if (r_v_ok) begin
                        w_res.vertex_found    = 1'b1;
                        w_res.vertex_position = r_best_rank;
                        w_res.vertex_dist_sq  = r_best_d2;
                    end
                end else begin
                    w_res.status = nps_pkg::ST_NONE;
                end
            end
            nps_pkg::OP_APPEND: begin
                w_res.status = r_drop ? nps_pkg::ST_FULL : nps_pkg::ST_OK;
            end
            nps_pkg::OP_CLEAR, nps_pkg::OP_NOP: begin
                w_res.status = nps_pkg::ST_OK;
            end
            default: begin
                w_res.status = nps_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scale |-> (LW'(w_root) * LW'(w_root) <= r_len2))
        else $error("square root above its operand");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.seg_update |-> (r_rem < REMW'(w_root)))
        else $error("division remainder not below divisor");

    a_vtx_after_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.vtx_update |-> r_seg_ok)
        else $error("vertex search without a found segment");

endmodule
